@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/b58dec_pkg.sv @@
`timescale 1ns / 1ps
package b58dec_pkg;

  localparam int unsigned FULL_CHARS  = 11;
  localparam int unsigned FULL_BYTES  = 8;
  localparam int unsigned BASE        = 58;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_SYMBOL = 2'd1,
    ST_BAD_LENGTH = 2'd2,
    ST_OVERFLOW   = 2'd3
  } status_t;

  // One finished block, as handed from the front to the back.
  typedef struct packed {
    logic [63:0] acc;
    logic [3:0]  nbytes;
    status_t     status;
    logic        eom;
  } blk_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } digit_t;

  function automatic digit_t digit_of(input logic [7:0] sym);
    digit_t d;
    logic [7:0] v;
    v = 8'd0;
    d.valid = 1'b1;
    if (sym >= 8'h31 && sym <= 8'h39)      v = sym - 8'h31;
    else if (sym >= 8'h41 && sym <= 8'h48) v = sym - 8'h38;
    else if (sym >= 8'h4A && sym <= 8'h4E) v = sym - 8'h39;
    else if (sym >= 8'h50 && sym <= 8'h5A) v = sym - 8'h3A;
    else if (sym >= 8'h61 && sym <= 8'h6B) v = sym - 8'h40;
    else if (sym >= 8'h6D && sym <= 8'h7A) v = sym - 8'h41;
    else d.valid = 1'b0;
    d.value = v[5:0];
    return d;
  endfunction

  // Byte count for a block of n characters; zero marks an invalid length.
  function automatic logic [3:0] bytes_for_len(input logic [3:0] n);
    logic [3:0] b;
    unique case (n)
      4'd2:    b = 4'd1;
      4'd3:    b = 4'd2;
      4'd5:    b = 4'd3;
      4'd6:    b = 4'd4;
      4'd7:    b = 4'd5;
      4'd9:    b = 4'd6;
      4'd10:   b = 4'd7;
      4'd11:   b = 4'd8;
      default: b = 4'd0;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/b58dec_queue.sv @@
`timescale 1ns / 1ps
module b58dec_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  b58dec_pkg::blk_t  wr_data,
  output logic              full,
  input  logic              rd,
  output logic              rd_valid,
  output b58dec_pkg::blk_t  rd_data
);
  import b58dec_pkg::*;

  blk_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_wr;
  logic do_rd;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];
  assign do_wr    = wr && !full;
  assign do_rd    = rd && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/b58dec_front.sv @@
`timescale 1ns / 1ps
module b58dec_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        symbol,
  input  logic              end_of_message,
  output logic              blk_push,
  output b58dec_pkg::blk_t  blk
);
  import b58dec_pkg::*;

  logic [63:0] accumulator;
  logic        overflow_seen;
  logic [3:0]  chars_in_block;
  logic        bad_symbol_seen;
  logic        discarding;

  digit_t      dig;
  logic [70:0] prod;
  logic [63:0] acc_next;
  logic        ovf_next;
  logic        bad_next;
  logic [3:0]  cnt_next;
  logic        block_end;
  logic [3:0]  nbytes;
  logic [63:0] high_mask;
  status_t     status;

  always_comb begin
    dig       = digit_of(symbol);
    prod      = {7'd0, accumulator} * 71'(BASE) + 71'(dig.value & {6{dig.valid}});
    acc_next  = prod[63:0];
    ovf_next  = overflow_seen || (prod[70:64] != 7'd0);
    bad_next  = bad_symbol_seen || !dig.valid;
    cnt_next  = chars_in_block + 4'd1;
    block_end = (cnt_next == 4'(FULL_CHARS)) || end_of_message;
    nbytes    = bytes_for_len(cnt_next);
    high_mask = ~64'd0 << {nbytes, 3'b000};
    if (nbytes == 4'd0) begin
      status = ST_BAD_LENGTH;
    end else if (bad_next) begin
      status = ST_BAD_SYMBOL;
    end else if (ovf_next) begin
      status = ST_OVERFLOW;
    end else if (nbytes < 4'(FULL_BYTES) && (acc_next & high_mask) != 64'd0) begin
      status = ST_OVERFLOW;
    end else begin
      status = ST_OK;
    end
  end

  assign blk_push   = accept && !discarding && block_end;
  assign blk.acc    = (status == ST_OK) ? acc_next : 64'd0;
  assign blk.nbytes = nbytes;
  assign blk.status = status;
  assign blk.eom    = end_of_message;

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator     <= '0;
      overflow_seen   <= 1'b0;
      chars_in_block  <= '0;
      bad_symbol_seen <= 1'b0;
      discarding      <= 1'b0;
    end else if (accept) begin
      if (discarding || block_end) begin
        // clear block state at every block end and on every character of a swallowed message
        accumulator     <= '0;
        overflow_seen   <= 1'b0;
        chars_in_block  <= '0;
        bad_symbol_seen <= 1'b0;
        if (discarding) begin
          discarding <= !end_of_message;
        end else begin
          discarding <= (status != ST_OK) && !end_of_message;
        end
      end else begin
        accumulator     <= acc_next;
        overflow_seen   <= ovf_next;
        chars_in_block  <= cnt_next;
        bad_symbol_seen <= bad_next;
      end
    end
  end

endmodule

@@ rtl/b58dec_back.sv @@
`timescale 1ns / 1ps
module b58dec_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  b58dec_pkg::blk_t  q_data,
  output logic              q_take,
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        data_byte,
  output logic [1:0]        status,
  output logic              last_of_block,
  output logic              last_of_message
);
  import b58dec_pkg::*;

  blk_t       cur;
  logic       busy;
  logic [2:0] idx;

  logic       is_last;
  logic [3:0] sel_full;
  logic [2:0] sel;
  logic       popped;

  always_comb begin
    sel_full = cur.nbytes - 4'd1 - {1'b0, idx};
    sel      = sel_full[2:0];
    is_last  = (cur.status != ST_OK) || ({1'b0, idx} == cur.nbytes - 4'd1);
  end

  assign popped          = pop && busy;
  assign q_take          = q_valid && (!busy || (popped && is_last));
  assign empty           = !busy;
  assign data_byte       = (cur.status == ST_OK) ? cur.acc[{sel, 3'b000} +: 8] : 8'd0;
  assign status          = cur.status;
  assign last_of_block   = is_last;
  assign last_of_message = is_last && cur.eom;

  always_ff @(posedge clk) begin
    if (q_take) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (q_take) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (popped) begin
      if (is_last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

endmodule

@@ rtl/base58_block_decoder.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Streaming base58 block decoder. Feed the encoded text one character per
// word on symbol, with end_of_message high on its final character; a new
// character is taken every cycle while full is low. Characters group into
// blocks of 11, each folded in as acc*58+digit by one constant multiply-add
// per cycle in the front end. A full block yields 8 big-endian bytes, a final
// short block of 2, 3, 5, 6, 7, 9 or 10 characters yields 1 to 7 bytes, and a
// failing block yields one error word (status 1 bad symbol, 2 bad final
// length, 3 overflow, data_byte zero) after which input is swallowed up to
// end_of_message. Finished blocks wait in a four-entry queue and the back end
// hands out one byte per cycle while pop is high, so the sustained rate is one
// character per cycle in and at most one word per cycle out; the first byte of
// a block shows on the result ports once the block has been written into the
// queue and then loaded into the back end's block register. full rises only
// when the consumer stalls long enough for four blocks to stack up behind the
// one being handed out. Bytes already delivered from earlier blocks of a
// failing message stand; drop them downstream.
module base58_block_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] symbol,
  input  logic       end_of_message,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] data_byte,
  output logic [1:0] status,
  output logic       last_of_block,
  output logic       last_of_message
);
  import b58dec_pkg::*;

  logic accept;
  logic blk_push;
  blk_t blk;
  logic q_valid;
  blk_t q_data;
  logic q_take;

  // accept a character only when the queue can hold a finished block
  assign accept = push && !full;

  b58dec_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .symbol         (symbol),
    .end_of_message (end_of_message),
    .blk_push       (blk_push),
    .blk            (blk)
  );

  b58dec_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (blk_push),
    .wr_data  (blk),
    .full     (full),
    .rd       (q_take),
    .rd_valid (q_valid),
    .rd_data  (q_data)
  );

  b58dec_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .q_take          (q_take),
    .empty           (empty),
    .pop             (pop),
    .data_byte       (data_byte),
    .status          (status),
    .last_of_block   (last_of_block),
    .last_of_message (last_of_message)
  );

  // an error word always closes its block
  `ASSERT_IMPLIES(a_err_is_last, clk, rst, !empty && status != ST_OK, last_of_block)
  // a message never ends in the middle of a block
  `ASSERT_IMPLIES(a_lom_is_lob, clk, rst, !empty && last_of_message, last_of_block)
  // more bytes of the same block follow a popped inner byte
  `ASSERT_NEXT(a_block_continues, clk, rst, pop && !empty && !last_of_block, !empty)
  // the front never pushes a block into a full queue
  `ASSERT_IMPLIES(a_no_push_full, clk, rst, blk_push, !full)

endmodule

@@ tb/base58_block_decoder_tb.sv @@
`timescale 1ns / 1ps
module base58_block_decoder_tb;
  import b58dec_pkg::*;

  // Give up when no word moves either way for this many cycles. The longest
  // quiet stretch in a correct run is the long output hold-off (HOLD_CYCLES)
  // plus one idle burst ahead of it.
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 150;
  localparam int RANDOM_CHARS = 80;

  // Digit i of the alphabet sits in byte i counted from the top.
  localparam logic [8*58-1:0] ALPHABET =
    "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

  typedef struct packed {
    logic [7:0] data;
    status_t    st;
    logic       lob;
    logic       lom;
  } dec_word_t;

  typedef struct packed {
    logic [7:0] sym;
    logic       eom;
    logic       typed;
    dec_word_t  want;
  } row_t;

  // Directed text. Rows with typed set carry the one word that the character
  // must produce; the other rows go through the decoder model below.
  localparam row_t PLAN [23] = '{
    // a lone character is an illegal final length
    {"1",   1'b1, 1'b1, {8'h00, ST_BAD_LENGTH, 1'b1, 1'b1}},
    // shortest legal block: "11" is one zero byte
    {"1",   1'b0, 1'b0, {8'h00, ST_OK,         1'b0, 1'b0}},
    {"1",   1'b1, 1'b1, {8'h00, ST_OK,         1'b1, 1'b1}},
    // "zz" is 3363, too big for the single byte of a 2-character block
    {"z",   1'b0, 1'b0, {8'h00, ST_OK,         1'b0, 1'b0}},
    {"z",   1'b1, 1'b1, {8'h00, ST_OVERFLOW,   1'b1, 1'b1}},
    // all-zero byte is not a digit
    {8'h00, 1'b0, 1'b0, {8'h00, ST_OK,         1'b0, 1'b0}},
    {"1",   1'b1, 1'b1, {8'h00, ST_BAD_SYMBOL, 1'b1, 1'b1}},
    // bad symbol in a 4-character block: the length error wins
    {8'hFF, 1'b0, 1'b0, {8'h00, ST_OK,         1'b0, 1'b0}},
    {"2",   1'b0, 1'b0, {8'h00, ST_OK,         1'b0, 1'b0}},
    {"3",   1'b0, 1'b0, {8'h00, ST_OK,         1'b0, 1'b0}},
    {"4",   1'b1, 1'b1, {8'h00, ST_BAD_LENGTH, 1'b1, 1'b1}},
    // eleven top digits exceed 2^64; the message goes on, so swallow the rest
    {"z",   1'b0, 1'b0, {8'h00, ST_OK,         1'b0, 1'b0}},
    {"z",   1'b0, 1'b0, {8'h00, ST_OK,         1'b0, 1'b0}},
    {"z",   1'b0, 1'b0, {8'h00, ST_OK,         1'b0, 1'b0}},
    {"z",   1'b0, 1'b0, {8'h00, ST_OK,         1'b0, 1'b0}},
    {"z",   1'b0, 1'b0, {8'h00, ST_OK,         1'b0, 1'b0}},
    {"z",   1'b0, 1'b0, {8'h00, ST_OK,         1'b0, 1'b0}},
    {"z",   1'b0, 1'b0, {8'h00, ST_OK,         1'b0, 1'b0}},
    {"z",   1'b0, 1'b0, {8'h00, ST_OK,         1'b0, 1'b0}},
    {"z",   1'b0, 1'b0, {8'h00, ST_OK,         1'b0, 1'b0}},
    {"z",   1'b0, 1'b0, {8'h00, ST_OK,         1'b0, 1'b0}},
    {"z",   1'b0, 1'b1, {8'h00, ST_OVERFLOW,   1'b1, 1'b0}},
    // swallowed; its end mark reopens the stream
    {"0",   1'b1, 1'b0, {8'h00, ST_OK,         1'b0, 1'b0}}
  };

  logic clk = 1'b0;
  logic rst;
  logic push;
  logic full;
  logic [7:0] symbol;
  logic end_of_message;
  logic empty;
  logic pop;
  logic [7:0] data_byte;
  logic [1:0] status;
  logic last_of_block;
  logic last_of_message;

  // Row-typed expectation travels with the character it belongs to.
  logic row_typed;
  dec_word_t row_word;

  // Decoder model state.
  logic [63:0] acc = '0;
  bit acc_ovf = 1'b0;
  logic [3:0] blk_len = '0;
  bit blk_bad = 1'b0;
  bit swallowing = 1'b0;
  dec_word_t bytes_due [$];

  // Message text under construction for the random part.
  logic [7:0] text [$];

  int errors = 0;
  int quiet_cycles = 0;
  int chars_decoded = 0;
  int chars_swallowed = 0;
  int words_checked = 0;
  int error_words = 0;
  int full_cycles = 0;
  int rand_base = 0;
  bit hold_req = 1'b0;
  bit holding = 1'b0;
  bit calm = 1'b0;

  base58_block_decoder uut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .symbol(symbol),
    .end_of_message(end_of_message),
    .empty(empty),
    .pop(pop),
    .data_byte(data_byte),
    .status(status),
    .last_of_block(last_of_block),
    .last_of_message(last_of_message)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] alpha_char(input int i);
    return ALPHABET[8*(57-i) +: 8];
  endfunction

  // Digit value of a text byte, or -1 when it is outside the alphabet.
  function automatic int digit_value(input logic [7:0] sym);
    for (int i = 0; i < 58; i++) begin
      if (alpha_char(i) == sym) return i;
    end
    return -1;
  endfunction

  // Bytes that a block of n characters stands for; zero marks a length
  // that no byte count encodes to.
  function automatic int block_bytes(input int n);
    case (n)
      2:       return 1;
      3:       return 2;
      5:       return 3;
      6:       return 4;
      7:       return 5;
      9:       return 6;
      10:      return 7;
      11:      return 8;
      default: return 0;
    endcase
  endfunction

  task automatic clear_block_state();
    acc = '0;
    acc_ovf = 1'b0;
    blk_len = '0;
    blk_bad = 1'b0;
  endtask

  // Fold one accepted character into the model and queue the words that it
  // releases: nothing mid-block, the block's bytes or one error word at the
  // block end.
  task automatic decode_char(input logic [7:0] sym, input logic eom);
    int d;
    int nb;
    logic [69:0] wide;
    status_t st;
    dec_word_t w;
    if (swallowing) begin
      // drop everything up to the end of the failed message
      if (eom) begin
        swallowing = 1'b0;
        clear_block_state();
      end
      return;
    end
    d = digit_value(sym);
    if (d < 0) begin
      // count a bad symbol as zero, report it at the block end
      blk_bad = 1'b1;
      d = 0;
    end
    wide = {6'd0, acc} * 70'd58 + 70'(d);
    if (wide[69:64] != 6'd0) acc_ovf = 1'b1;
    acc = wide[63:0];
    blk_len = blk_len + 4'd1;
    if (blk_len < 4'(FULL_CHARS) && !eom) return;

    nb = block_bytes(int'(blk_len));
    st = ST_OK;
    if (nb == 0) st = ST_BAD_LENGTH;
    else if (blk_bad) st = ST_BAD_SYMBOL;
    else if (acc_ovf) st = ST_OVERFLOW;
    else if (nb < 8 && (acc >> (8 * nb)) != 64'd0) st = ST_OVERFLOW;

    if (st != ST_OK) begin
      w = {8'h00, st, 1'b1, eom};
      bytes_due = {bytes_due, w};
      clear_block_state();
      if (!eom) swallowing = 1'b1;
      return;
    end
    // emit big-endian: most significant byte of the block first
    for (int k = 0; k < nb; k++) begin
      w.data = 8'(acc >> (8 * (nb - 1 - k)));
      w.st = ST_OK;
      w.lob = (k == nb - 1);
      w.lom = (k == nb - 1) && eom;
      bytes_due = {bytes_due, w};
    end
    clear_block_state();
  endtask

  // Append v as n base58 digits, most significant first, zero-padded.
  task automatic add_digits(input logic [63:0] v, input int n);
    logic [7:0] digs [0:10];
    for (int i = n - 1; i >= 0; i--) begin
      digs[i] = alpha_char(int'(v % 64'd58));
      v = v / 64'd58;
    end
    for (int i = 0; i < n; i++) text = {text, digs[i]};
  endtask

  // Build one random message. Two thirds are well-formed encodings of
  // random data; the rest are raw noise, a stray bad symbol, an illegal
  // final length, or a block whose leading 'z' pushes it past its bytes.
  task automatic build_message();
    int kind;
    int nfull;
    int tail;
    int nb;
    int lead;
    logic [63:0] v;
    logic [7:0] junk;
    text.delete();
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 15)) text = {text, 8'($urandom_range(0, 255))};
      return;
    end
    nfull = $urandom_range(0, 2);
    if (kind >= 18 && kind < 26) begin
      case ($urandom_range(0, 2))
        0:       tail = 1;
        1:       tail = 4;
        default: tail = 8;
      endcase
    end else begin
      case ($urandom_range(0, 7))
        0:       tail = 0;
        1:       tail = 2;
        2:       tail = 3;
        3:       tail = 5;
        4:       tail = 6;
        5:       tail = 7;
        6:       tail = 9;
        default: tail = 10;
      endcase
      if (nfull == 0 && tail == 0) tail = 2;
    end
    repeat (nfull) begin
      v = {$urandom, $urandom};
      if ($urandom_range(0, 3) == 0) v = v >> $urandom_range(0, 63);
      add_digits(v, FULL_CHARS);
    end
    if (tail > 0) begin
      nb = block_bytes(tail);
      v = {$urandom, $urandom};
      if ($urandom_range(0, 3) == 0) v = v >> $urandom_range(0, 63);
      if (nb > 0 && nb < 8) v = v & ((64'd1 << (8 * nb)) - 64'd1);
      add_digits(v, tail);
    end
    if (kind >= 26 && kind < 34) begin
      lead = (tail > 0) ? nfull * FULL_CHARS : (nfull - 1) * FULL_CHARS;
      text[lead] = "z";
    end
    if (kind >= 8 && kind < 18) begin
      do junk = 8'($urandom_range(0, 255)); while (digit_value(junk) >= 0);
      text[$urandom_range(0, text.size() - 1)] = junk;
    end
  endtask

  // Offer one character and hold it until the edge that takes it.
  task automatic offer(input logic [7:0] sym, input logic eom, input logic typed,
                       input dec_word_t w);
    push <= 1'b1;
    symbol <= sym;
    end_of_message <= eom;
    row_typed <= typed;
    row_word <= w;
    do @(posedge clk); while (full);
  endtask

  task automatic rest(input int n);
    push <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Stop offering and wait until every expected word has come out.
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (bytes_due.size() != 0) @(posedge clk);
  endtask

  // Take accepted characters into the model first, then check the word that
  // leaves at the same edge, so one edge is handled in one fixed order.
  always @(posedge clk) begin : scoreboard_p
    dec_word_t got;
    dec_word_t want;
    int depth0;
    if (!rst) begin
      quiet_cycles++;
      if (push && full) full_cycles++;
      if (push && !full) begin
        quiet_cycles = 0;
        if (swallowing) chars_swallowed++;
        else chars_decoded++;
        depth0 = bytes_due.size();
        decode_char(symbol, end_of_message);
        if (row_typed) begin
          // the row states its word outright: use that one
          while (bytes_due.size() > depth0) bytes_due.delete(bytes_due.size() - 1);
          bytes_due = {bytes_due, row_word};
        end
      end
      if (pop && !empty) begin
        quiet_cycles = 0;
        got = {data_byte, status_t'(status), last_of_block, last_of_message};
        words_checked++;
        if (got.st != ST_OK) error_words++;
        if (bytes_due.size() == 0) begin
          errors++;
          if (errors <= 20)
            $display("%0t: unexpected word: data %02h status %0d block-end %0b message-end %0b",
                     $time, got.data, got.st, got.lob, got.lom);
        end else begin
          want = bytes_due.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 20)
              $display({"%0t: mismatch: expected data %02h status %0d block-end %0b ",
                        "message-end %0b, got data %02h status %0d block-end %0b ",
                        "message-end %0b"},
                       $time, want.data, want.st, want.lob, want.lom,
                       got.data, got.st, got.lob, got.lom);
          end
        end
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Output side: pop in runs of random length, idle in bursts of random length
  // until the run turns calm, and on request hold off long enough for the block
  // to fill up and push back on its input.
  initial begin : consumer_p
    pop <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        holding = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding = 1'b0;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  initial begin : producer_p
    int msg_no;
    bit lively;
    bit paused;
    rst <= 1'b1;
    push <= 1'b0;
    symbol <= 8'h00;
    end_of_message <= 1'b0;
    row_typed <= 1'b0;
    row_word <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table back to back.
    foreach (PLAN[r]) offer(PLAN[r].sym, PLAN[r].eom, PLAN[r].typed, PLAN[r].want);
    settle();

    // Random messages until enough characters have been taken. Ask for the
    // long output stall right away and keep offering through all of it;
    // after it, pause once until the block has run dry. Drop all idling
    // near the end.
    rand_base = chars_decoded + chars_swallowed;
    msg_no = 0;
    paused = 1'b0;
    hold_req = 1'b1;
    while ((chars_decoded + chars_swallowed - rand_base < RANDOM_CHARS) ||
           holding || hold_req) begin
      build_message();
      if (!paused && msg_no >= 3 && !holding && !hold_req) begin
        settle();
        paused = 1'b1;
      end
      lively = !calm && $urandom_range(0, 2) != 0;
      for (int k = 0; k < text.size(); k++) begin
        offer(text[k], k == text.size() - 1, 1'b0, '0);
        if (lively && !holding && !hold_req && $urandom_range(0, 4) == 0)
          rest($urandom_range(1, 19));
      end
      calm = (chars_decoded + chars_swallowed - rand_base) > 60;
      msg_no++;
    end

    // Drain, then watch a little longer for stray words.
    settle();
    repeat (20) @(posedge clk);

    $display("Decoded %0d characters and swallowed %0d after failed blocks.",
             chars_decoded, chars_swallowed);
    $display("Checked %0d output words (%0d error words); input held off on %0d cycles.",
             words_checked, error_words, full_cycles);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/b58dec_pkg.sv
rtl/b58dec_queue.sv
rtl/b58dec_front.sv
rtl/b58dec_back.sv
rtl/base58_block_decoder.sv
tb/base58_block_decoder_tb.sv
